>>> sv/fmcbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge mapper package
// Shared constants, access codes and the per-transaction result tag.
// ----------------------------------------------------------------------------
`default_nettype none

package fmcbm_pkg;

    localparam int ROM_ADDR_BITS_DEF = 16;
    localparam int RAM_ADDR_BITS     = 13;

    localparam logic [15:0] ADDR_UNLOCK_LO = 16'h5ffe;
    localparam logic [15:0] ADDR_UNLOCK_HI = 16'h5fff;
    localparam logic [15:0] ADDR_SND_ADDR  = 16'h7ff4;
    localparam logic [15:0] ADDR_SND_DATA  = 16'h7ff5;
    localparam logic [15:0] ADDR_CTRL      = 16'h7ff6;
    localparam logic [15:0] ADDR_BANK      = 16'h7ff7;

    localparam logic [7:0] UNLOCK_LO_KEY = 8'h4d;
    localparam logic [7:0] UNLOCK_HI_KEY = 8'h69;
    localparam logic [7:0] CTRL_MASK     = 8'h11;
    localparam logic [7:0] BYTE_OPEN     = 8'hff;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_IO    = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RD_CONST = 2'd0,
        RD_ROM   = 2'd1,
        RD_RAM   = 2'd2
    } t_rd_sel;

    typedef struct packed {
        t_rd_sel    rd_sel;
        logic [7:0] rd_const;
        logic       sound_write;
        logic       sound_port;
        logic [7:0] sound_data;
    } t_result;

endpackage

`default_nettype wire

>>> sv/fmcbm_ram.sv
// ----------------------------------------------------------------------------
// Cartridge mapper single-port RAM
// Synchronous byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmcbm_ram #(
    parameter int ADDR_BITS = 13
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [7:0]           i_wdata,
    output logic      [7:0]           o_rdata
);

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/fmcbm_ctrl.sv
// ----------------------------------------------------------------------------
// Cartridge mapper control
// Decodes each transaction, holds the bank, control and unlock registers,
// drives both memories and sweeps the SRAM to zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fmcbm_ctrl #(
    parameter int ROM_ADDR_BITS = fmcbm_pkg::ROM_ADDR_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire fmcbm_pkg::t_action               i_action,
    input  wire logic [15:0]                      i_address,
    input  wire logic [7:0]                       i_write_data,
    output logic                                  o_busy,
    output logic                                  o_rom_we,
    output logic                                  o_rom_re,
    output logic [ROM_ADDR_BITS-1:0]              o_rom_addr,
    output logic                                  o_ram_we,
    output logic                                  o_ram_re,
    output logic [fmcbm_pkg::RAM_ADDR_BITS-1:0]   o_ram_addr,
    output logic [7:0]                            o_ram_wdata,
    output fmcbm_pkg::t_result                    o_result
);

    import fmcbm_pkg::*;

    logic [1:0]               r_bank;
    logic [7:0]               r_ctrl;
    logic [7:0]               r_unlock_lo;
    logic [7:0]               r_unlock_hi;
    logic                     r_ram_en;
    logic                     r_busy;
    logic [RAM_ADDR_BITS-1:0] r_clr_addr;

    logic [1:0]               n_bank;
    logic [7:0]               n_ctrl;
    logic [7:0]               n_unlock_lo;
    logic [7:0]               n_unlock_hi;
    logic                     n_ram_en;

    logic                     wr;
    logic                     in_window;
    logic                     sram_window;
    logic                     snd_addr_hit;
    logic [15:0]              rom_bank_addr;
    t_result                  res;

    assign wr           = i_accept && (i_action == ACT_WRITE);
    assign in_window    = (i_address[15:14] == 2'b01);
    assign sram_window  = (i_address[15:13] == 3'b010);
    assign snd_addr_hit = (i_address == ADDR_SND_ADDR) || (i_address == ADDR_SND_DATA);
    assign rom_bank_addr = {r_bank, i_address[13:0]};

    always_comb begin
        n_unlock_lo = r_unlock_lo;
        n_unlock_hi = r_unlock_hi;
        n_ram_en    = r_ram_en;
        n_ctrl      = r_ctrl;
        n_bank      = r_bank;
        if (wr && sram_window) begin
            if (i_address == ADDR_UNLOCK_LO) begin
                n_unlock_lo = i_write_data;
            end
            if (i_address == ADDR_UNLOCK_HI) begin
                n_unlock_hi = i_write_data;
            end
            n_ram_en = (n_unlock_lo == UNLOCK_LO_KEY) && (n_unlock_hi == UNLOCK_HI_KEY);
        end
        if (wr && (i_address == ADDR_CTRL)) begin
            n_ctrl = i_write_data & CTRL_MASK;
        end
        if (wr && (i_address == ADDR_BANK)) begin
            n_bank = i_write_data[1:0];
        end
    end

    // Read selection and sound forwarding use the state left by earlier transactions.
    always_comb begin
        res.rd_sel      = RD_CONST;
        res.rd_const    = BYTE_OPEN;
        res.sound_write = 1'b0;
        res.sound_port  = 1'b0;
        res.sound_data  = 8'h00;
        if ((i_action == ACT_READ) && in_window) begin
            priority if (i_address == ADDR_CTRL) begin
                res.rd_const = r_ctrl;
            end else if (i_address == ADDR_BANK) begin
                res.rd_const = {6'b000000, r_bank};
            end else if (r_ram_en) begin
                if (!i_address[13]) begin
                    res.rd_sel = RD_RAM;
                end
            end else begin
                res.rd_sel = RD_ROM;
            end
        end
        if (r_ctrl[0] && ((i_action == ACT_IO) || ((i_action == ACT_WRITE) && snd_addr_hit))) begin
            res.sound_write = 1'b1;
            res.sound_port  = i_address[0];
            res.sound_data  = i_write_data;
        end
    end

    always_comb begin
        o_rom_re    = i_accept && (i_action == ACT_READ);
        o_rom_we    = i_accept && (i_action == ACT_LOAD);
        o_rom_addr  = (i_action == ACT_LOAD) ? i_address[ROM_ADDR_BITS-1:0]
                                             : rom_bank_addr[ROM_ADDR_BITS-1:0];
        o_ram_re    = i_accept && (i_action == ACT_READ);
        if (r_busy) begin
            o_ram_we    = 1'b1;
            o_ram_addr  = r_clr_addr;
            o_ram_wdata = 8'h00;
        end else begin
            o_ram_we    = wr && sram_window && r_ram_en;
            o_ram_addr  = i_address[RAM_ADDR_BITS-1:0];
            o_ram_wdata = i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= '0;
            r_ctrl      <= '0;
            r_unlock_lo <= '0;
            r_unlock_hi <= '0;
            r_ram_en    <= 1'b0;
            r_busy      <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_bank      <= n_bank;
            r_ctrl      <= n_ctrl;
            r_unlock_lo <= n_unlock_lo;
            r_unlock_hi <= n_unlock_hi;
            r_ram_en    <= n_ram_en;
            if (r_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_result = res;

endmodule

`default_nettype wire

>>> sv/fm_cartridge_bank_sram_mapper_top.sv
// ----------------------------------------------------------------------------
// Bank-switched cartridge mapper with battery SRAM and sound-chip port
// One transaction in gives one transaction out, in order.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one access per transaction: tuser holds the
//   access kind (read, write, sound port write, ROM image load) and tdata
//   the address and the write byte. The master stream returns one result
//   per access: the read byte (0xff for anything but an in-window read)
//   and the forwarded sound-chip write, if any.
//   Each access passes through the synchronous ROM/SRAM read stage and
//   then the output register. Throughput is one access per cycle while
//   the receiver is ready and the sweep is done, set by the single port
//   of each memory, which serves one read or one write per cycle.
//   After reset the SRAM is swept to zero, one byte a cycle, over all
//   8192 bytes; the input is not ready during that sweep. The ROM contents are
//   kept across reset and must be loaded before the window is read.
//   When the receiver stalls, the output register and the read stage hold
//   their results and the input stops taking transactions once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_cartridge_bank_sram_mapper_top #(
    parameter int ROM_ADDR_BITS = fmcbm_pkg::ROM_ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // address[15:0], write_data[23:16]
    input  wire logic [1:0]  i_s_axis_tuser,  // action[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,  // read_data[7:0], sound_data[15:8]
    output logic      [1:0]  o_m_axis_tuser   // sound_write[0], sound_port[1]
);

    import fmcbm_pkg::*;

    logic                     busy;
    logic                     accept;
    logic                     s1_adv;
    logic                     rom_we;
    logic                     rom_re;
    logic [ROM_ADDR_BITS-1:0] rom_addr;
    logic                     ram_we;
    logic                     ram_re;
    logic [RAM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]               ram_wdata;
    logic [7:0]               rom_q;
    logic [7:0]               ram_q;
    t_result                  result;
    logic [7:0]               s1_read;

    logic                     r_s1_valid;
    t_result                  r_s1;
    logic                     r_out_valid;
    logic [15:0]              r_out_data;
    logic [1:0]               r_out_user;

    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !busy && (!r_s1_valid || s1_adv);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    fmcbm_ctrl #(
        .ROM_ADDR_BITS(ROM_ADDR_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (t_action'(i_s_axis_tuser)),
        .i_address   (i_s_axis_tdata[15:0]),
        .i_write_data(i_s_axis_tdata[23:16]),
        .o_busy      (busy),
        .o_rom_we    (rom_we),
        .o_rom_re    (rom_re),
        .o_rom_addr  (rom_addr),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .o_result    (result)
    );

    fmcbm_ram #(
        .ADDR_BITS(ROM_ADDR_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_we   (rom_we),
        .i_re   (rom_re),
        .i_addr (rom_addr),
        .i_wdata(i_s_axis_tdata[23:16]),
        .o_rdata(rom_q)
    );

    fmcbm_ram #(
        .ADDR_BITS(RAM_ADDR_BITS)
    ) u_sram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_q)
    );

    // Memory read data is held by the RAMs until the next accepted transaction.
    always_comb begin
        case (r_s1.rd_sel)
            RD_ROM:   s1_read = rom_q;
            RD_RAM:   s1_read = ram_q;
            RD_CONST: s1_read = r_s1.rd_const;
            default:  s1_read = BYTE_OPEN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= result;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data <= {r_s1.sound_data, s1_read};
            r_out_user <= {r_s1.sound_port, r_s1.sound_write};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_no_accept_in_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_s_axis_tready)
        else $error("input accepted during SRAM sweep");

    a_s1_held_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("read stage lost a result while stalled");

    a_accept_reaches_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted transaction did not enter read stage");

    a_sound_fields_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
            (!o_m_axis_tuser[1] && (o_m_axis_tdata[15:8] == 8'h00)))
        else $error("sound fields set without a sound write");

    a_read_no_sound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[7:0] != BYTE_OPEN)) |-> !o_m_axis_tuser[0])
        else $error("read result carries a sound write");

endmodule

`default_nettype wire
